/* sv/tqb_pkg.sv */
// tqb_pkg: shared types and constants for the quad tangent basis core.
// No dependencies; used by tqb_unitize, tqb_cross and quad_tangent_basis_core.
package tqb_pkg;

   // Q16.16 input component and Q2.14 output component
   typedef logic signed [31:0] q16_type;
   typedef logic signed [15:0] q14_type;

   // |N.y| above this (0.9 in Q2.14, truncated) selects +Z as helper axis
   localparam logic [15:0] HELPER_LIMIT = 16'd14745;

   // Rounding offset for Q4.28 to Q2.14
   localparam logic [32:0] ROUND_HALF = 33'd8192;

   localparam q14_type SAT_MAX = 16'sd32767;
   localparam q14_type SAT_MIN = -16'sd32768;

endpackage

/* sv/tqb_unitize.sv */
// tqb_unitize: pipelined vector normalizer (pre-shift, sum of squares, integer
// square root, per-lane restoring divide, round). Uses tqb_pkg.
module tqb_unitize #(
   parameter int TAG_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  tqb_pkg::q16_type    in_c [3],
   input  logic [TAG_W-1:0]    in_tag,
   output logic                out_valid,
   output tqb_pkg::q14_type    out_u [3],
   output logic                out_zero,
   output logic [TAG_W-1:0]    out_tag
);

   localparam int SQ_STAGES = 8;
   localparam int SQ_STEPS  = 4;
   localparam int DV_STAGES = 4;
   localparam int DV_STEPS  = 4;
   localparam int LAST      = SQ_STAGES + DV_STAGES;

   // stage A: magnitudes and pre-shift count
   logic             a_valid_ff;
   logic [2:0]       a_sign_ff;
   logic [31:0]      a_mag_ff [3];
   logic [4:0]       a_shift_ff;
   logic             a_zero_ff;
   logic [TAG_W-1:0] a_tag_ff;
   logic [2:0]       a_sign_in;
   logic [31:0]      a_mag_in [3];
   logic [4:0]       a_shift_in;
   logic             a_zero_in;

   always_comb begin
      logic [31:0] orv;
      logic [4:0]  msb;
      orv = '0;
      msb = '0;
      for (int l = 0; l < 3; l++) begin
         a_sign_in[l] = in_c[l][31];
         a_mag_in[l]  = in_c[l][31] ? 32'(-in_c[l]) : 32'(in_c[l]);
         orv          = orv | a_mag_in[l];
      end
      for (int i = 0; i < 32; i++) begin
         if (orv[i]) msb = 5'(i);
      end
      a_zero_in  = (orv == '0);
      a_shift_in = (orv[31] | orv[30]) ? 5'd0 : 5'd30 - msb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
      end
      if (en) begin
         a_sign_ff  <= a_sign_in;
         a_mag_ff   <= a_mag_in;
         a_shift_ff <= a_shift_in;
         a_zero_ff  <= a_zero_in;
         a_tag_ff   <= in_tag;
      end
   end

   // stage B: shifted magnitudes, largest now at least 2^30
   logic             b_valid_ff;
   logic [2:0]       b_sign_ff;
   logic [31:0]      b_mag_ff [3];
   logic             b_zero_ff;
   logic [TAG_W-1:0] b_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
      if (en) begin
         for (int l = 0; l < 3; l++) b_mag_ff[l] <= a_mag_ff[l] << a_shift_ff;
         b_sign_ff <= a_sign_ff;
         b_zero_ff <= a_zero_ff;
         b_tag_ff  <= a_tag_ff;
      end
   end

   // stage C: squares
   logic             s_valid_ff;
   logic [2:0]       s_sign_ff;
   logic [31:0]      s_mag_ff [3];
   logic [63:0]      s_sq_ff [3];
   logic             s_zero_ff;
   logic [TAG_W-1:0] s_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (en) begin
         s_valid_ff <= b_valid_ff;
      end
      if (en) begin
         for (int l = 0; l < 3; l++) s_sq_ff[l] <= b_mag_ff[l] * b_mag_ff[l];
         s_mag_ff  <= b_mag_ff;
         s_sign_ff <= b_sign_ff;
         s_zero_ff <= b_zero_ff;
         s_tag_ff  <= b_tag_ff;
      end
   end

   // carried side data, index 0 is the sum stage, LAST the end of divide
   logic             c_valid_ff [0:LAST];
   logic             c_zero_ff  [0:LAST];
   logic [2:0]       c_sign_ff  [0:LAST];
   logic [31:0]      c_mag_ff   [0:LAST][0:2];
   logic [TAG_W-1:0] c_tag_ff   [0:LAST];

   // square root state per stage
   logic [63:0] r_rad_ff  [0:SQ_STAGES];
   logic [33:0] r_rem_ff  [0:SQ_STAGES];
   logic [31:0] r_root_ff [0:SQ_STAGES];
   logic [63:0] r_rad_in  [SQ_STAGES];
   logic [33:0] r_rem_in  [SQ_STAGES];
   logic [31:0] r_root_in [SQ_STAGES];

   // stage D: sum of squares
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff[0] <= 1'b0;
      end else if (en) begin
         c_valid_ff[0] <= s_valid_ff;
      end
      if (en) begin
         r_rad_ff[0]  <= s_sq_ff[0] + s_sq_ff[1] + s_sq_ff[2];
         r_rem_ff[0]  <= '0;
         r_root_ff[0] <= '0;
         c_zero_ff[0] <= s_zero_ff;
         c_sign_ff[0] <= s_sign_ff;
         for (int l = 0; l < 3; l++) c_mag_ff[0][l] <= s_mag_ff[l];
         c_tag_ff[0]  <= s_tag_ff;
      end
   end

   // side data moves one stage per enabled cycle
   for (genvar p = 0; p < LAST; p++) begin : g_carry
      always_ff @(posedge clock) begin
         if (reset) begin
            c_valid_ff[p+1] <= 1'b0;
         end else if (en) begin
            c_valid_ff[p+1] <= c_valid_ff[p];
         end
         if (en) begin
            c_zero_ff[p+1] <= c_zero_ff[p];
            c_sign_ff[p+1] <= c_sign_ff[p];
            for (int l = 0; l < 3; l++) c_mag_ff[p+1][l] <= c_mag_ff[p][l];
            c_tag_ff[p+1]  <= c_tag_ff[p];
         end
      end
   end

   // integer square root, two radicand bits per step
   for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sqrt
      always_comb begin
         logic [63:0] rad;
         logic [33:0] rem;
         logic [31:0] root;
         logic [33:0] trial;
         rad  = r_rad_ff[g];
         rem  = r_rem_ff[g];
         root = r_root_ff[g];
         for (int k = 0; k < SQ_STEPS; k++) begin
            rem   = {rem[31:0], rad[63:62]};
            rad   = {rad[61:0], 2'b00};
            trial = {root, 2'b01};
            if (rem >= trial) begin
               rem  = rem - trial;
               root = {root[30:0], 1'b1};
            end else begin
               root = {root[30:0], 1'b0};
            end
         end
         r_rad_in[g]  = rad;
         r_rem_in[g]  = rem;
         r_root_in[g] = root;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_rad_ff[g+1]  <= r_rad_in[g];
            r_rem_ff[g+1]  <= r_rem_in[g];
            r_root_ff[g+1] <= r_root_in[g];
         end
      end
   end

   // restoring divide of mag * 2^15 by the root, three lanes
   logic [32:0] dv_rem_ff [1:DV_STAGES][0:2];
   logic [15:0] dv_q_ff   [1:DV_STAGES][0:2];
   logic [31:0] dv_s_ff   [1:DV_STAGES];

   for (genvar g = 0; g < DV_STAGES; g++) begin : g_div
      logic [32:0] rem_in [3];
      logic [15:0] q_in   [3];
      logic [31:0] s_cur;

      if (g == 0) begin : g_first
         assign s_cur = r_root_ff[SQ_STAGES];
      end else begin : g_rest
         assign s_cur = dv_s_ff[g];
      end

      always_comb begin
         logic [32:0] rem;
         logic [15:0] q;
         for (int l = 0; l < 3; l++) begin
            if (g == 0) begin
               rem = {1'b0, c_mag_ff[SQ_STAGES][l]};
               q   = '0;
            end else begin
               rem = dv_rem_ff[(g == 0) ? 1 : g][l];
               q   = dv_q_ff[(g == 0) ? 1 : g][l];
            end
            for (int k = 0; k < DV_STEPS; k++) begin
               if (rem >= {1'b0, s_cur}) begin
                  rem = rem - {1'b0, s_cur};
                  q   = {q[14:0], 1'b1};
               end else begin
                  q   = {q[14:0], 1'b0};
               end
               rem = {rem[31:0], 1'b0};
            end
            rem_in[l] = rem;
            q_in[l]   = q;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int l = 0; l < 3; l++) begin
               dv_rem_ff[g+1][l] <= rem_in[l];
               dv_q_ff[g+1][l]   <= q_in[l];
            end
            dv_s_ff[g+1] <= s_cur;
         end
      end
   end

   // output stage: round half up on the magnitude, restore sign
   logic             o_valid_ff;
   tqb_pkg::q14_type o_u_ff [3];
   tqb_pkg::q14_type o_u_in [3];
   logic             o_zero_ff;
   logic [TAG_W-1:0] o_tag_ff;

   always_comb begin
      logic [16:0] rnd;
      for (int l = 0; l < 3; l++) begin
         rnd = ({1'b0, dv_q_ff[DV_STAGES][l]} + 17'd1) >> 1;
         if (c_zero_ff[LAST]) begin
            o_u_in[l] = '0;
         end else if (c_sign_ff[LAST][l]) begin
            o_u_in[l] = -$signed(rnd[15:0]);
         end else begin
            o_u_in[l] = $signed(rnd[15:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (en) begin
         o_valid_ff <= c_valid_ff[LAST];
      end
      if (en) begin
         o_u_ff    <= o_u_in;
         o_zero_ff <= c_zero_ff[LAST];
         o_tag_ff  <= c_tag_ff[LAST];
      end
   end

   assign out_valid = o_valid_ff;
   assign out_u     = o_u_ff;
   assign out_zero  = o_zero_ff;
   assign out_tag   = o_tag_ff;

endmodule

/* sv/tqb_cross.sv */
// tqb_cross: two-stage V = N x U with rounding to Q2.14 and saturation.
// Uses tqb_pkg.
module tqb_cross (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  tqb_pkg::q14_type in_n [3],
   input  tqb_pkg::q14_type in_u [3],
   input  logic             in_deg,
   output logic             out_valid,
   output tqb_pkg::q14_type out_n [3],
   output tqb_pkg::q14_type out_u [3],
   output tqb_pkg::q14_type out_v [3],
   output logic             out_deg
);

   // stage 1: six Q4.28 products, pairs (a*b, c*d) per V component
   logic                    p_valid_ff;
   logic signed [31:0]      p_ab_ff [3];
   logic signed [31:0]      p_cd_ff [3];
   tqb_pkg::q14_type        p_n_ff [3];
   tqb_pkg::q14_type        p_u_ff [3];
   logic                    p_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= in_valid;
      end
      if (en) begin
         p_ab_ff[0] <= in_n[1] * in_u[2];
         p_cd_ff[0] <= in_n[2] * in_u[1];
         p_ab_ff[1] <= in_n[2] * in_u[0];
         p_cd_ff[1] <= in_n[0] * in_u[2];
         p_ab_ff[2] <= in_n[0] * in_u[1];
         p_cd_ff[2] <= in_n[1] * in_u[0];
         p_n_ff     <= in_n;
         p_u_ff     <= in_u;
         p_deg_ff   <= in_deg;
      end
   end

   // stage 2: difference, round half away from zero, saturate
   logic             o_valid_ff;
   tqb_pkg::q14_type o_v_ff [3];
   tqb_pkg::q14_type o_v_in [3];
   tqb_pkg::q14_type o_n_ff [3];
   tqb_pkg::q14_type o_u_ff [3];
   logic             o_deg_ff;

   always_comb begin
      logic signed [32:0] d;
      logic [32:0]        mag;
      logic [32:0]        q;
      for (int l = 0; l < 3; l++) begin
         d   = 33'(p_ab_ff[l]) - 33'(p_cd_ff[l]);
         mag = d[32] ? 33'(-d) : 33'(d);
         q   = (mag + tqb_pkg::ROUND_HALF) >> 14;
         if (!d[32]) begin
            o_v_in[l] = (q > 33'd32767) ? tqb_pkg::SAT_MAX : $signed(q[15:0]);
         end else if (q > 33'd32768) begin
            o_v_in[l] = tqb_pkg::SAT_MIN;
         end else begin
            o_v_in[l] = -$signed(q[15:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (en) begin
         o_valid_ff <= p_valid_ff;
      end
      if (en) begin
         o_v_ff   <= o_v_in;
         o_n_ff   <= p_n_ff;
         o_u_ff   <= p_u_ff;
         o_deg_ff <= p_deg_ff;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_v     = o_v_ff;
   assign out_n     = o_n_ff;
   assign out_u     = o_u_ff;
   assign out_deg   = o_deg_ff;

endmodule

/* sv/quad_tangent_basis_core.sv */
// quad_tangent_basis_core: orthonormal frame (N, U, V) from a Q16.16 normal.
// Depends on tqb_pkg, tqb_unitize and tqb_cross.
//
// Usage: one beat on req_* carries a normal (x, y, z) in signed Q16.16. One
// beat on rsp_* returns the unit normal, the U axis and the V axis in signed
// Q2.14, plus a degenerate flag for an all-zero normal (all axes then zero).
// A request passes through normalizing N, picking the helper axis,
// normalizing U and the V cross product, in that order, before rsp_valid.
// Throughput is one beat per cycle while the pipe is not held; the square
// root (4 bits per stage) and the three lane dividers (4 quotient bits per
// stage) are fully pipelined.
// All stages advance together while the output register is empty or being
// taken; while rsp_ready is low with a result waiting, req_ready drops and
// the whole pipe holds, so nothing is lost or repeated.
// Reset (synchronous, active high) clears every valid bit; no cleanup pass
// is needed and req_ready is high in the first cycle after reset.
module quad_tangent_basis_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [31:0]     req_normal_x,
   input  logic signed [31:0]     req_normal_y,
   input  logic signed [31:0]     req_normal_z,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic signed [15:0]     rsp_unit_normal_x,
   output logic signed [15:0]     rsp_unit_normal_y,
   output logic signed [15:0]     rsp_unit_normal_z,
   output logic signed [15:0]     rsp_tangent_u_x,
   output logic signed [15:0]     rsp_tangent_u_y,
   output logic signed [15:0]     rsp_tangent_u_z,
   output logic signed [15:0]     rsp_bitangent_v_x,
   output logic signed [15:0]     rsp_bitangent_v_y,
   output logic signed [15:0]     rsp_bitangent_v_z,
   output logic                   rsp_degenerate
);

   localparam int TAG_W = 1 + 3 * 16;

   // global advance: output register free or being drained
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // normalize the input normal
   tqb_pkg::q16_type n_in [3];
   tqb_pkg::q14_type n1_u [3];
   logic             n1_valid;
   logic             n1_zero;

   assign n_in[0] = req_normal_x;
   assign n_in[1] = req_normal_y;
   assign n_in[2] = req_normal_z;

   tqb_unitize #(.TAG_W(1)) u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_c      (n_in),
      .in_tag    (1'b0),
      .out_valid (n1_valid),
      .out_u     (n1_u),
      .out_zero  (n1_zero),
      .out_tag   ()
   );

   // helper axis choice and helper x N
   logic             h_valid_ff;
   tqb_pkg::q16_type h_c_ff [3];
   tqb_pkg::q16_type h_c_in [3];
   tqb_pkg::q14_type h_n_ff [3];
   logic             h_deg_ff;

   always_comb begin
      logic [15:0] ay;
      ay = n1_u[1][15] ? 16'(-n1_u[1]) : 16'(n1_u[1]);
      if (ay > tqb_pkg::HELPER_LIMIT) begin
         h_c_in[0] = -32'(n1_u[1]);
         h_c_in[1] = 32'(n1_u[0]);
         h_c_in[2] = '0;
      end else begin
         h_c_in[0] = -32'(n1_u[2]);
         h_c_in[1] = '0;
         h_c_in[2] = 32'(n1_u[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (en) begin
         h_valid_ff <= n1_valid;
      end
      if (en) begin
         h_c_ff   <= h_c_in;
         h_n_ff   <= n1_u;
         h_deg_ff <= n1_zero;
      end
   end

   // normalize the tangent, N and the flag ride along as a tag
   tqb_pkg::q14_type u2_u [3];
   logic             u2_valid;
   logic [TAG_W-1:0] u2_tag_in;
   logic [TAG_W-1:0] u2_tag;
   tqb_pkg::q14_type t_n [3];

   assign u2_tag_in = {h_deg_ff, h_n_ff[0], h_n_ff[1], h_n_ff[2]};

   tqb_unitize #(.TAG_W(TAG_W)) u_tan (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (h_valid_ff),
      .in_c      (h_c_ff),
      .in_tag    (u2_tag_in),
      .out_valid (u2_valid),
      .out_u     (u2_u),
      .out_zero  (),
      .out_tag   (u2_tag)
   );

   assign t_n[0] = u2_tag[47:32];
   assign t_n[1] = u2_tag[31:16];
   assign t_n[2] = u2_tag[15:0];

   // V axis and output register
   tqb_pkg::q14_type o_n [3];
   tqb_pkg::q14_type o_u [3];
   tqb_pkg::q14_type o_v [3];

   tqb_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (u2_valid),
      .in_n      (t_n),
      .in_u      (u2_u),
      .in_deg    (u2_tag[TAG_W-1]),
      .out_valid (rsp_valid),
      .out_n     (o_n),
      .out_u     (o_u),
      .out_v     (o_v),
      .out_deg   (rsp_degenerate)
   );

   assign rsp_unit_normal_x = o_n[0];
   assign rsp_unit_normal_y = o_n[1];
   assign rsp_unit_normal_z = o_n[2];
   assign rsp_tangent_u_x   = o_u[0];
   assign rsp_tangent_u_y   = o_u[1];
   assign rsp_tangent_u_z   = o_u[2];
   assign rsp_bitangent_v_x = o_v[0];
   assign rsp_bitangent_v_y = o_v[1];
   assign rsp_bitangent_v_z = o_v[2];

endmodule

/* bench/tb_quad_tangent_basis_core.sv */
// Self-checking bench for quad_tangent_basis_core: drives Q16.16 normals and
// checks each returned frame against an in-bench integer model.
// Depends on tqb_pkg and quad_tangent_basis_core.
`timescale 1ns / 100ps

module tb_quad_tangent_basis_core;

   typedef struct {
      tqb_pkg::q14_type n[3];
      tqb_pkg::q14_type u[3];
      tqb_pkg::q14_type v[3];
      logic             degen;
   } frame_type;

   // ---------------------------------------------------------------------
   // Frame prediction and scoreboard
   // ---------------------------------------------------------------------
   class frame_scoreboard_type;
      frame_type pending[$];
      int        mismatches;

      static function logic [63:0] mag(longint a);
         return (a < 0) ? 64'(-a) : 64'(a);
      endfunction

      static function logic [63:0] int_sqrt(logic [63:0] val);
         logic [63:0] res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > val) bitv >>= 2;
         while (bitv != 0) begin
            if (val >= res + bitv) begin
               val -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      // scale to unit length in Q2.14; returns 0 on an all-zero vector
      static function bit to_unit(longint a[3], output int o[3]);
         logic [63:0] m[3], big, total, root, q;
         big = 0;
         total = 0;
         for (int i = 0; i < 3; i++) begin
            m[i] = mag(a[i]);
            if (m[i] > big) big = m[i];
         end
         o = '{0, 0, 0};
         if (big == 0) return 0;
         while (big < (64'd1 << 30)) begin
            big <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
         end
         for (int i = 0; i < 3; i++) total += m[i] * m[i];
         root = int_sqrt(total);
         for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 15) / root + 1) >> 1;
            o[i] = (a[i] < 0) ? -int'(q) : int'(q);
         end
         return 1;
      endfunction

      // a*b - c*d, Q4.28 to Q2.14, half away from zero, saturated
      static function tqb_pkg::q14_type cross_term(int a, int b, int c, int d);
         longint p, r;
         logic [63:0] q;
         p = longint'(a) * b - longint'(c) * d;
         q = (mag(p) + 64'd8192) >> 14;
         r = (p < 0) ? -longint'(q) : longint'(q);
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         return tqb_pkg::q14_type'(r);
      endfunction

      static function frame_type predict_frame(tqb_pkg::q16_type x,
                                               tqb_pkg::q16_type y,
                                               tqb_pkg::q16_type z);
         frame_type f;
         longint nv[3], hv[3];
         int n[3], u[3], ny_mag;
         nv = '{longint'(x), longint'(y), longint'(z)};
         f.degen = 0;
         if (!to_unit(nv, n)) begin
            for (int i = 0; i < 3; i++) begin
               f.n[i] = 0; f.u[i] = 0; f.v[i] = 0;
            end
            f.degen = 1;
            return f;
         end
         ny_mag = (n[1] < 0) ? -n[1] : n[1];
         if (ny_mag > int'(tqb_pkg::HELPER_LIMIT))
            hv = '{-longint'(n[1]), longint'(n[0]), 0};
         else hv = '{-longint'(n[2]), 0, longint'(n[0])};
         void'(to_unit(hv, u));
         for (int i = 0; i < 3; i++) begin
            f.n[i] = tqb_pkg::q14_type'(n[i]);
            f.u[i] = tqb_pkg::q14_type'(u[i]);
         end
         f.v[0] = cross_term(n[1], u[2], n[2], u[1]);
         f.v[1] = cross_term(n[2], u[0], n[0], u[2]);
         f.v[2] = cross_term(n[0], u[1], n[1], u[0]);
         return f;
      endfunction

      function void note_normal(tqb_pkg::q16_type x, tqb_pkg::q16_type y,
                                tqb_pkg::q16_type z);
         pending.push_back(predict_frame(x, y, z));
      endfunction

      function void check_frame(frame_type got);
         frame_type exp_f;
         bit bad;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
            return;
         end
         exp_f = pending.pop_front();
         bad = (got.degen !== exp_f.degen);
         for (int i = 0; i < 3; i++)
            bad |= (got.n[i] !== exp_f.n[i]) || (got.u[i] !== exp_f.u[i])
                   || (got.v[i] !== exp_f.v[i]);
         if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("frame mismatch at %0t: exp N(%0d %0d %0d) U(%0d %0d %0d)",
                  $realtime, exp_f.n[0], exp_f.n[1], exp_f.n[2], exp_f.u[0],
                  exp_f.u[1], exp_f.u[2]);
               $display("   exp V(%0d %0d %0d) d%0b", exp_f.v[0], exp_f.v[1],
                  exp_f.v[2], exp_f.degen);
               $display("   got N(%0d %0d %0d) U(%0d %0d %0d)", got.n[0], got.n[1],
                  got.n[2], got.u[0], got.u[1], got.u[2]);
               $display("   got V(%0d %0d %0d) d%0b", got.v[0], got.v[1],
                  got.v[2], got.degen);
            end
         end
      endfunction
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_ready;
   tqb_pkg::q16_type req_normal_x = 0, req_normal_y = 0, req_normal_z = 0;
   logic             rsp_valid;
   logic             rsp_ready = 0;
   tqb_pkg::q14_type rsp_unit_normal_x, rsp_unit_normal_y, rsp_unit_normal_z;
   tqb_pkg::q14_type rsp_tangent_u_x, rsp_tangent_u_y, rsp_tangent_u_z;
   tqb_pkg::q14_type rsp_bitangent_v_x, rsp_bitangent_v_y, rsp_bitangent_v_z;
   logic             rsp_degenerate;

   int send_idle_pct = 25;
   int recv_idle_pct = 55;
   bit stim_done = 0;
   frame_scoreboard_type frames = new();

   quad_tangent_basis_core uut (.*);

   always #6 clock = ~clock;

   // Result side: sample at the rising edge, update ready at the falling edge
   always @(posedge clock) begin
      frame_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.n = '{rsp_unit_normal_x, rsp_unit_normal_y, rsp_unit_normal_z};
         got.u = '{rsp_tangent_u_x, rsp_tangent_u_y, rsp_tangent_u_z};
         got.v = '{rsp_bitangent_v_x, rsp_bitangent_v_y, rsp_bitangent_v_z};
         got.degen = rsp_degenerate;
         frames.check_frame(got);
      end
   end

   always @(negedge clock)
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);

   // one beat: optional idle gap, then hold valid until accepted
   task automatic send_normal(tqb_pkg::q16_type x, tqb_pkg::q16_type y,
                              tqb_pkg::q16_type z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_normal_x <= x;
      req_normal_y <= y;
      req_normal_z <= z;
      do @(posedge clock); while (!req_ready);
      frames.note_normal(x, y, z);
      @(negedge clock);
   endtask

   function automatic tqb_pkg::q16_type rand_comp();
      case ($urandom_range(5))
         0: return tqb_pkg::q16_type'($urandom);
         1: return tqb_pkg::q16_type'($urandom_range(0, 4095)) - 2048;
         2: return $urandom_range(1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
         3: return 0;
         default: return tqb_pkg::q16_type'($signed($urandom) >>> $urandom_range(31));
      endcase
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++)
         send_normal(rand_comp(), rand_comp(), rand_comp());
   endtask

   initial begin
      tqb_pkg::q16_type ext[6] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0001_0000,
                                   -32'sh0001_0000, 1, -1};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: zero normal, axes, extremes, helper threshold area
      send_normal(0, 0, 0);
      for (int i = 0; i < 6; i++) send_normal(ext[i], 0, 0);
      for (int i = 0; i < 6; i++) send_normal(0, ext[i], 0);
      for (int i = 0; i < 6; i++) send_normal(0, 0, ext[i]);
      send_normal(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_normal(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
      send_normal(32'sh0000_7000, 32'sh0000_E666, 0);
      send_normal(32'sh0000_6F00, -32'sh0000_E667, 32'sh100);
      random_phase(600);
      send_idle_pct = 55;
      recv_idle_pct = 25;
      random_phase(600);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(600);
      req_valid <= 0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (frames.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (frames.mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* files.f */
sv/tqb_pkg.sv
sv/tqb_unitize.sv
sv/tqb_cross.sv
sv/quad_tangent_basis_core.sv
bench/tb_quad_tangent_basis_core.sv
